FILE: hw/rtl/sle_pkg.sv
// sle_pkg: operation and status codes, plus the command and status
// structs that join the sorted list controller and datapath.
// No dependencies.
package sle_pkg;

  // operation codes carried by in_func
  localparam logic [1:0] FUNC_INSERT   = 2'd0;
  localparam logic [1:0] FUNC_DELETE   = 2'd1;
  localparam logic [1:0] FUNC_RD_ASC   = 2'd2;
  localparam logic [1:0] FUNC_RD_DESC  = 2'd3;

  // result status codes carried by out_status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_TOP,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    WA_IDX,
    WA_IDX_P1,
    WA_IDX_M1
  } wr_addr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic         latch;       // capture the incoming request
    idx_op_t      idx_op;
    logic         rd_en;       // read the entry at the next index
    logic         wr_en;
    wr_addr_sel_t wr_addr_sel;
    logic         wr_from_ram; // write read data instead of the request value
    cnt_op_t      cnt_op;
    logic         out_load;
    logic         out_from_ram;
    logic [1:0]   out_status;
    logic         out_last;
  } sle_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       cnt_full;
    logic       lt;        // read entry below request value
    logic       eq;        // read entry equal to request value
    logic       idx_zero;
    logic       idx_top;   // index at the highest filled slot
    logic       out_free;
  } sle_stat_t;

endpackage

FILE: hw/rtl/sle_ram.sv
// sle_ram: generic single write, single read RAM with registered read.
// No dependencies.
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/sle_datapath.sv
// sle_datapath: entry RAM, scan index, entry count, request and result
// registers. Depends on sle_pkg and sle_ram.
module sle_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sle_pkg::sle_cmd_t   cmd,
  output sle_pkg::sle_stat_t  stat,
  input  logic [1:0]          in_func,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_item,
  output logic [1:0]          out_status,
  output logic                out_last
);
  import sle_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [1:0]         op_r;
  logic signed [31:0] val_r;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      cnt_m1_w;
  logic [AW-1:0]      top_w;
  logic               out_valid_r;
  logic signed [31:0] out_item_r;
  logic [1:0]         out_status_r;
  logic               out_last_r;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic [31:0]        rd_data;
  logic signed [31:0] rd_val;

  assign cnt_m1_w = cnt_r - CW'(1);
  assign top_w    = cnt_m1_w[AW-1:0];
  assign rd_val   = $signed(rd_data);

  always_comb begin
    unique case (cmd.idx_op)
      IDX_HOLD: idx_nxt = idx_r;
      IDX_ZERO: idx_nxt = '0;
      IDX_TOP:  idx_nxt = top_w;
      IDX_INC:  idx_nxt = idx_r + AW'(1);
      IDX_DEC:  idx_nxt = idx_r - AW'(1);
      default:  idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    unique case (cmd.cnt_op)
      CNT_HOLD: cnt_nxt = cnt_r;
      CNT_INC:  cnt_nxt = cnt_r + CW'(1);
      CNT_DEC:  cnt_nxt = cnt_m1_w;
      default:  cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_addr_sel)
      WA_IDX:    wr_addr = idx_r;
      WA_IDX_P1: wr_addr = idx_r + AW'(1);
      WA_IDX_M1: wr_addr = idx_r - AW'(1);
      default:   wr_addr = idx_r;
    endcase
  end

  assign wr_data = cmd.wr_from_ram ? rd_data : val_r;

  sle_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_nxt),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.latch) begin
      op_r  <= in_func;
      val_r <= in_value;
    end
    if (cmd.out_load) begin
      out_item_r   <= cmd.out_from_ram ? rd_val : 32'sd0;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
    end
  end

  assign stat.op       = op_r;
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.cnt_full = (cnt_r == CW'(CAPACITY));
  assign stat.lt       = (rd_val < val_r);
  assign stat.eq       = (rd_val == val_r);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.idx_top  = (idx_r == top_w);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

FILE: hw/rtl/sle_ctrl.sv
// sle_ctrl: sequencer for insert, delete and readout requests.
// Depends on sle_pkg.
module sle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sle_pkg::sle_stat_t stat,
  output sle_pkg::sle_cmd_t  cmd
);
  import sle_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DISPATCH  = 3'd1;
  localparam logic [2:0] S_INS_SCAN  = 3'd2;
  localparam logic [2:0] S_INS_LAST  = 3'd3;
  localparam logic [2:0] S_DEL_SCAN  = 3'd4;
  localparam logic [2:0] S_DEL_SHIFT = 3'd5;
  localparam logic [2:0] S_RD_EMIT   = 3'd6;
  localparam logic [2:0] S_RESP      = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] resp_r, resp_nxt;
  logic       rd_last;

  // final readout entry: top slot going up, slot zero going down
  assign rd_last = (stat.op == FUNC_RD_ASC) ? stat.idx_top : stat.idx_zero;

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          FUNC_INSERT: begin
            if (stat.cnt_full) begin
              resp_nxt  = ST_FULL;
              state_nxt = S_RESP;
            end else if (stat.cnt_zero) begin
              cmd.idx_op = IDX_ZERO;
              state_nxt  = S_INS_LAST;
            end else begin
              cmd.idx_op = IDX_TOP;
              cmd.rd_en  = 1'b1;
              state_nxt  = S_INS_SCAN;
            end
          end
          FUNC_DELETE: begin
            if (stat.cnt_zero) begin
              resp_nxt  = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              cmd.idx_op = IDX_ZERO;
              cmd.rd_en  = 1'b1;
              state_nxt  = S_DEL_SCAN;
            end
          end
          default: begin
            if (stat.cnt_zero) begin
              resp_nxt  = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              cmd.idx_op = (stat.op == FUNC_RD_ASC) ? IDX_ZERO : IDX_TOP;
              cmd.rd_en  = 1'b1;
              state_nxt  = S_RD_EMIT;
            end
          end
        endcase
      end
      S_INS_SCAN: begin
        // walk down from the top, moving each entry not below the value up
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_IDX_P1;
        if (stat.lt) begin
          cmd.cnt_op = CNT_INC;
          resp_nxt   = ST_OK;
          state_nxt  = S_RESP;
        end else begin
          cmd.wr_from_ram = 1'b1;
          if (stat.idx_zero) begin
            state_nxt = S_INS_LAST;
          end else begin
            cmd.idx_op = IDX_DEC;
            cmd.rd_en  = 1'b1;
          end
        end
      end
      S_INS_LAST: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_IDX;
        cmd.cnt_op      = CNT_INC;
        resp_nxt        = ST_OK;
        state_nxt       = S_RESP;
      end
      S_DEL_SCAN: begin
        priority if (stat.eq) begin
          if (stat.idx_top) begin
            cmd.cnt_op = CNT_DEC;
            resp_nxt   = ST_OK;
            state_nxt  = S_RESP;
          end else begin
            cmd.idx_op = IDX_INC;
            cmd.rd_en  = 1'b1;
            state_nxt  = S_DEL_SHIFT;
          end
        end else if (stat.lt && !stat.idx_top) begin
          cmd.idx_op = IDX_INC;
          cmd.rd_en  = 1'b1;
        end else begin
          resp_nxt  = ST_NOTFOUND;
          state_nxt = S_RESP;
        end
      end
      S_DEL_SHIFT: begin
        // close the gap: move each later entry down one slot
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_IDX_M1;
        cmd.wr_from_ram = 1'b1;
        if (stat.idx_top) begin
          cmd.cnt_op = CNT_DEC;
          resp_nxt   = ST_OK;
          state_nxt  = S_RESP;
        end else begin
          cmd.idx_op = IDX_INC;
          cmd.rd_en  = 1'b1;
        end
      end
      S_RD_EMIT: begin
        // read data holds while the result register is blocked
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_ram = 1'b1;
          cmd.out_status   = ST_OK;
          cmd.out_last     = rd_last;
          if (rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_op = (stat.op == FUNC_RD_ASC) ? IDX_INC : IDX_DEC;
            cmd.rd_en  = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    resp_r <= resp_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: hw/rtl/sorted_list_engine_core.sv
// sorted_list_engine_core: top level of the sorted list engine.
// Depends on sle_pkg, sle_ctrl, sle_datapath (and sle_ram through it).
//
//   channel   direction  handshake           payload
//   in_       request    in_valid/in_stall   in_func, in_value
//   out_      result     out_valid/out_stall out_item, out_status, out_last
//
// in_stall is high while a request is in progress; the next request is taken
//   only after the controller has returned to idle. The entry RAM has one read
//   and one write port, so scans and shifts move one entry per cycle.
// Reset clears only the count, out_valid and the control state; the entry RAM
//   is not cleared, since only slots below the count are ever read.
// out_stall holds the result register; the sequencer waits on it and a new
//   request is taken only once the previous one has issued its last result.
module sorted_list_engine_core #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_item,
  output logic [1:0]         out_status,
  output logic               out_last
);
  import sle_pkg::*;

  // commands flow controller -> datapath, status flows back
  sle_cmd_t  cmd;
  sle_stat_t stat;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entries live in RAM slots 0 .. count-1 in ascending order
  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (in_func),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
